// ===== src/g2drw_pkg.sv =====
// Package for the 2D graphics register window: transaction types, register
// offsets, hub index map and the hub slot lookup function.
// No dependencies.
package g2drw_pkg;

	localparam int HubSlots = 5;
	localparam int HubSlotW = 3;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [11:0] OFF_CMD_PORT   = 12'h000;
	localparam logic [11:0] OFF_MMU_PORT   = 12'h3FC;
	localparam logic [11:0] OFF_HUB_INDEX  = 12'h510;
	localparam logic [11:0] OFF_HUB_DATA   = 12'h518;
	localparam logic [11:0] OFF_IRQ_ENABLE = 12'h438;
	localparam logic [11:0] OFF_IRQ_STATUS = 12'h418;
	localparam logic [11:0] OFF_DONE_COUNT = 12'h4E0;
	localparam logic [11:0] OFF_ID_A       = 12'h004;
	localparam logic [11:0] OFF_ID_B       = 12'hFE4;
	localparam logic [11:0] OFF_ID_C       = 12'hFE8;

	localparam int IrqG2dBit = 1;

	localparam logic [31:0] HUB_INDEX_MAP [HubSlots] = '{
		32'h0000_0A40, 32'h0000_0040, 32'h0000_0A42, 32'h0000_0046, 32'h0000_0047
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] offset;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_out;
		logic        fwd_valid;
		logic [15:0] fwd_addr;
		logic [31:0] fwd_data;
		logic        access_error;
	} rsp_t;

	typedef struct packed {
		logic                hit;
		logic [HubSlotW-1:0] slot;
	} hub_slot_t;

	function automatic hub_slot_t hub_lookup(input logic [31:0] idx);
		hub_slot_t r;
		r = '0;
		for (int i = 0; i < HubSlots; i++) begin
			if (!r.hit && HUB_INDEX_MAP[i] == idx) begin
				r.hit  = 1'b1;
				r.slot = HubSlotW'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== src/gpu2d_register_window_irq_unit.sv =====
// Top level of the 2D graphics register window with interrupt logic.
// Depends on g2drw_pkg.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  g2drw_pkg::req_t
// rsp      out        rsp_valid / rsp_ready  g2drw_pkg::rsp_t
//
// The input register captures a transaction when it is accepted; when it advances, the decode
// and state update move it into the result register. A new transaction is accepted every
// cycle while rsp is taken.
// A stalled result holds the result register and the input register, and
// req_ready stays high as long as the input register can move on.
// Reset clears the valid flags and the window state, not the input and result registers; no clearing pass is needed.
module gpu2d_register_window_irq_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  g2drw_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output g2drw_pkg::rsp_t  rsp
);
	import g2drw_pkg::*;

	logic        valid_s1;
	req_t        req_s1;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        cmd_pending_q;
	logic [15:0] cmd_addr_q;
	logic        mmu_pending_q;
	logic [15:0] mmu_addr_q;
	logic [31:0] hub_regs_q [HubSlots];
	logic [31:0] hub_index_q;
	logic [31:0] line_enable_q;
	logic [31:0] irq_status_q;
	logic [7:0]  done_count_q;
	logic        irq_level_q;

	logic        advance;
	rsp_t        rsp_d;
	hub_slot_t   rd_slot;
	hub_slot_t   wr_slot;
	logic [31:0] status_cleared;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rd_slot        = hub_lookup(hub_index_q);
	assign wr_slot        = hub_lookup({16'h0000, mmu_addr_q});
	assign status_cleared = irq_status_q & ~req_s1.write_data;

	always_comb begin
		rsp_d = '0;
		unique case (req_s1.kind)
			KIND_READ: begin
				unique case (req_s1.offset)
					OFF_IRQ_ENABLE: rsp_d.read_data = line_enable_q;
					OFF_IRQ_STATUS: rsp_d.read_data = irq_status_q;
					OFF_DONE_COUNT: rsp_d.read_data = {16'h0000, done_count_q, 8'h00};
					OFF_HUB_DATA: begin
						if (rd_slot.hit) begin
							rsp_d.read_data = hub_regs_q[rd_slot.slot];
						end else begin
							rsp_d.access_error = 1'b1;
						end
					end
					OFF_ID_A, OFF_ID_B, OFF_ID_C: rsp_d.read_data = '0;
					default: rsp_d.access_error = 1'b1;
				endcase
			end
			KIND_WRITE: begin
				unique case (req_s1.offset)
					OFF_CMD_PORT: begin
						if (cmd_pending_q) begin
							rsp_d.fwd_valid = 1'b1;
							rsp_d.fwd_addr  = cmd_addr_q;
							rsp_d.fwd_data  = req_s1.write_data;
						end
					end
					OFF_MMU_PORT: begin
						if (mmu_pending_q && !wr_slot.hit) begin
							rsp_d.access_error = 1'b1;
						end
					end
					OFF_HUB_INDEX, OFF_IRQ_ENABLE, OFF_IRQ_STATUS: ;
					default: rsp_d.access_error = 1'b1;
				endcase
			end
			default: ;
		endcase
		rsp_d.irq_out = irq_level_q;
		if (req_s1.kind == KIND_DONE && line_enable_q[IrqG2dBit]) begin
			rsp_d.irq_out = 1'b1;
		end else if (req_s1.kind == KIND_WRITE && req_s1.offset == OFF_IRQ_STATUS
				&& !status_cleared[IrqG2dBit]) begin
			rsp_d.irq_out = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_pending_q <= 1'b0;
			cmd_addr_q    <= '0;
			mmu_pending_q <= 1'b0;
			mmu_addr_q    <= '0;
			for (int i = 0; i < HubSlots; i++) begin
				hub_regs_q[i] <= '0;
			end
			hub_index_q   <= '0;
			line_enable_q <= '0;
			irq_status_q  <= '0;
			done_count_q  <= '0;
			irq_level_q   <= 1'b0;
		end else if (advance) begin
			irq_level_q <= rsp_d.irq_out;
			unique case (req_s1.kind)
				KIND_READ: begin
					if (req_s1.offset == OFF_DONE_COUNT) begin
						done_count_q <= '0;
					end
				end
				KIND_WRITE: begin
					unique case (req_s1.offset)
						OFF_CMD_PORT: begin
							if (!cmd_pending_q) begin
								cmd_addr_q <= req_s1.write_data[23:8];
							end
							cmd_pending_q <= !cmd_pending_q;
						end
						OFF_MMU_PORT: begin
							if (!mmu_pending_q) begin
								mmu_addr_q <= req_s1.write_data[23:8];
							end else if (wr_slot.hit) begin
								hub_regs_q[wr_slot.slot] <= req_s1.write_data;
							end
							mmu_pending_q <= !mmu_pending_q;
						end
						OFF_HUB_INDEX:  hub_index_q   <= req_s1.write_data;
						OFF_IRQ_ENABLE: line_enable_q <= req_s1.write_data;
						OFF_IRQ_STATUS: irq_status_q  <= status_cleared;
						default: ;
					endcase
				end
				KIND_DONE: begin
					if (done_count_q != 8'hFF) begin
						done_count_q <= done_count_q + 8'd1;
					end
					irq_status_q[IrqG2dBit] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		irq_level_q |-> irq_status_q[IrqG2dBit])
		else $error("Interrupt line high while its status bit is clear.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.fwd_valid && rsp_q.access_error))
		else $error("Forwarded pair flagged as an access error.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && rsp_d.fwd_valid |=> !cmd_pending_q)
		else $error("Command port still pending after forwarding a pair.");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("Accepted transaction lost before the input register.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("Input register changed while stalled.");

endmodule
